[rtl/period_locked_pulse_burst_defines.svh]
// Assertion helpers for the period locked pulse burst block.
// Each macro expects signals named clk and rst in the using module.
`ifndef PERIOD_LOCKED_PULSE_BURST_DEFINES_SVH
`define PERIOD_LOCKED_PULSE_BURST_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define PLPB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition is followed by another in the next cycle.
`define PLPB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PLPB_ASSERT(label, prop, msg)
`define PLPB_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

[rtl/plpb_pkg.sv]
package plpb_pkg;

  // Timer and field widths
  localparam int TMR_W   = 24;
  localparam int CNT_W   = 8;
  localparam int DUTY_W  = 11;
  localparam int OFS_W   = 24;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  localparam logic [TMR_W-1:0] TMR_MAX = {TMR_W{1'b1}};

  // Duty scaling and pulse end ratio (end when 1000*elapsed > 999*period)
  localparam int DUTY_SHIFT = 10;
  localparam int THR_NUM_I  = 999;
  localparam int THR_DEN_I  = 1000;
  localparam int DEN_W      = $clog2(THR_DEN_I + 1);

  // Serial arithmetic widths
  localparam int MUL_W  = TMR_W + DUTY_W;
  localparam int DVD_W  = TMR_W + DEN_W;
  localparam int STEP_W = $clog2(DVD_W);

  // Register indexes
  localparam logic [1:0] REG_PPP    = 2'd0;
  localparam logic [1:0] REG_DUTY   = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0]  PPP_RST    = CNT_W'(3);
  localparam logic [DUTY_W-1:0] DUTY_RST   = DUTY_W'(512);
  localparam logic [OFS_W-1:0]  OFFSET_RST = OFS_W'(10000);

  // Status and results of the serial arithmetic unit
  typedef struct packed {
    logic             busy;
    logic [TMR_W-1:0] high_time;
    logic [TMR_W-1:0] thr;
  } plpb_math_t;

endpackage

[rtl/plpb_math.sv]
module plpb_math (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [plpb_pkg::TMR_W-1:0]  period,
  input  logic [plpb_pkg::CNT_W-1:0]  blen,
  input  logic [plpb_pkg::DUTY_W-1:0] duty,
  output plpb_pkg::plpb_math_t        res
);
  import plpb_pkg::*;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_DIV_PP  = 3'd1;
  localparam logic [2:0] M_MUL_HI  = 3'd2;
  localparam logic [2:0] M_MUL_THR = 3'd3;
  localparam logic [2:0] M_DIV_THR = 3'd4;

  localparam logic [DUTY_W-1:0] THR_NUM  = DUTY_W'(THR_NUM_I);
  localparam logic [DEN_W-1:0]  THR_DEN  = DEN_W'(THR_DEN_I);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DVD_W - 1);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(DUTY_W - 1);

  logic [2:0]        mstate;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  dq;
  logic [DEN_W-1:0]  drem;
  logic [DEN_W-1:0]  dsor;
  logic [TMR_W-1:0]  pp;
  logic [MUL_W-1:0]  prod;
  logic [TMR_W-1:0]  high_time;
  logic [TMR_W-1:0]  thr;

  logic [DEN_W:0]    r_sh;
  logic [DEN_W:0]    r_diff;
  logic              r_ge;
  logic [DEN_W-1:0]  drem_step;
  logic [DVD_W-1:0]  dq_step;
  logic [TMR_W:0]    psum;
  logic [MUL_W-1:0]  prod_step;
  logic [TMR_W:0]    hi_raw;
  logic [TMR_W-1:0]  hi_sat;

  // One restoring divide step: shift in the next dividend bit, try subtract
  assign r_sh      = {drem, dq[DVD_W-1]};
  assign r_diff    = r_sh - {1'b0, dsor};
  assign r_ge      = (r_sh >= {1'b0, dsor});
  assign drem_step = r_ge ? r_diff[DEN_W-1:0] : r_sh[DEN_W-1:0];
  assign dq_step   = {dq[DVD_W-2:0], r_ge};

  // One shift-add multiply step: multiplier bits leave at the bottom
  assign psum      = {1'b0, prod[MUL_W-1:DUTY_W]} + (prod[0] ? {1'b0, pp} : '0);
  assign prod_step = {psum, prod[DUTY_W-1:1]};

  // Scale the duty product and clamp to the timer range
  assign hi_raw = prod_step[MUL_W-1:DUTY_SHIFT];
  assign hi_sat = hi_raw[TMR_W] ? TMR_MAX : hi_raw[TMR_W-1:0];

  // Sequence: period / count, that quotient * duty, that quotient * 999, then / 1000
  always_ff @(posedge clk) begin
    if (rst) begin
      mstate    <= M_IDLE;
      step      <= '0;
      high_time <= '0;
      thr       <= '0;
    end else begin
      unique case (mstate)
        M_IDLE: begin
          if (start) begin
            dq     <= {{DEN_W{1'b0}}, period};
            drem   <= '0;
            dsor   <= {{(DEN_W-CNT_W){1'b0}}, blen};
            step   <= '0;
            mstate <= M_DIV_PP;
          end
        end
        M_DIV_PP: begin
          dq   <= dq_step;
          drem <= drem_step;
          if (step == DIV_LAST) begin
            pp     <= dq_step[TMR_W-1:0];
            prod   <= {{TMR_W{1'b0}}, duty};
            step   <= '0;
            mstate <= M_MUL_HI;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        M_MUL_HI: begin
          if (step == MUL_LAST) begin
            high_time <= hi_sat;
            prod      <= {{TMR_W{1'b0}}, THR_NUM};
            step      <= '0;
            mstate    <= M_MUL_THR;
          end else begin
            prod <= prod_step;
            step <= step + STEP_W'(1);
          end
        end
        M_MUL_THR: begin
          prod <= prod_step;
          if (step == MUL_LAST) begin
            dq     <= prod_step[DVD_W-1:0];
            drem   <= '0;
            dsor   <= THR_DEN;
            step   <= '0;
            mstate <= M_DIV_THR;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        M_DIV_THR: begin
          dq   <= dq_step;
          drem <= drem_step;
          if (step == DIV_LAST) begin
            thr    <= dq_step[TMR_W-1:0];
            step   <= '0;
            mstate <= M_IDLE;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        default: begin
          mstate <= M_IDLE;
        end
      endcase
    end
  end

  assign res.busy      = (mstate != M_IDLE);
  assign res.high_time = high_time;
  assign res.thr       = thr;

endmodule

[rtl/period_locked_pulse_burst.sv]
// Period locked pulse burst generator. Each input request is one microsecond
// tick with the sampled reference level; each tick gives exactly one result
// request with the trigger level, the lock flag, the latched period and the
// burst busy flag. A tick's result sits in the output register from the next
// cycle if the output is free; a second result slot lets one more tick in
// while the output is stalled. The tick that locks the period starts a
// bit-serial arithmetic unit (a 34-step divide by the pulse count, two
// 11-step shift-add multiplies and a 34-step divide by 1000), so the input
// stalls while the unit is busy, once per reset. Registers sit on an APB-style
// port: pulse count at 0x0, duty in 1/1024 at 0x4, start offset at 0x8.
`include "period_locked_pulse_burst_defines.svh"
module period_locked_pulse_burst (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plpb_pkg::ADDR_W-1:0] paddr,
  input  logic [plpb_pkg::DATA_W-1:0] pwdata,
  output logic [plpb_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        ref_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        trigger_level,
  output logic                        period_valid,
  output logic [plpb_pkg::TMR_W-1:0]  measured_period,
  output logic                        burst_busy
);
  import plpb_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_PULSE = 2'd2;
  localparam logic [1:0] LOCK_CNT = 2'd2;

  typedef struct packed {
    logic             trig;
    logic             pvalid;
    logic [TMR_W-1:0] period;
    logic             busy;
  } res_t;

  function automatic logic [TMR_W-1:0] sat_inc(input logic [TMR_W-1:0] v);
    return (v == TMR_MAX) ? v : v + TMR_W'(1);
  endfunction

  // Configuration registers
  logic [CNT_W-1:0]  ppp;
  logic [DUTY_W-1:0] duty;
  logic [OFS_W-1:0]  offset;

  // Tick state
  logic              last_level;
  logic              armed;
  logic [1:0]        rise_cnt;
  logic [TMR_W-1:0]  edge_timer;
  logic [TMR_W-1:0]  period_latched;
  logic [1:0]        phase;
  logic [TMR_W-1:0]  phase_timer;
  logic [CNT_W-1:0]  pulses_done;
  logic              rise_pending;
  logic [TMR_W-1:0]  since_rise;

  // Next values
  logic              armed_next;
  logic [1:0]        rise_cnt_next;
  logic [TMR_W-1:0]  edge_timer_next;
  logic [TMR_W-1:0]  period_latched_next;
  logic [1:0]        phase_next;
  logic [TMR_W-1:0]  phase_timer_next;
  logic [CNT_W-1:0]  pulses_done_next;
  logic              rise_pending_next;
  logic [TMR_W-1:0]  since_rise_next;
  logic              trig_next;

  // Output stage
  res_t              out_res;
  res_t              res_slot;
  logic              res_valid;
  res_t              res_new;
  logic              out_free;

  logic              accept;
  logic              rise;
  logic              fall;
  logic              locked;
  logic              lock_now;
  logic              math_go;
  logic [CNT_W-1:0]  blen;
  logic              cfg_wr;
  plpb_math_t        math;

  assign accept   = in_valid && !in_stall;
  assign rise     = ref_level && !last_level;
  assign fall     = !ref_level && last_level;
  assign locked   = (rise_cnt == LOCK_CNT);
  assign blen     = (ppp == '0) ? CNT_W'(1) : ppp;
  assign lock_now = !locked && rise && armed && (rise_cnt + 2'd1 == LOCK_CNT);
  assign math_go  = accept && lock_now;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ppp    <= PPP_RST;
      duty   <= DUTY_RST;
      offset <= OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PPP:    ppp    <= pwdata[CNT_W-1:0];
        REG_DUTY:   duty   <= pwdata[DUTY_W-1:0];
        REG_OFFSET: offset <= pwdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PPP:    prdata = {{(DATA_W-CNT_W){1'b0}}, ppp};
      REG_DUTY:   prdata = {{(DATA_W-DUTY_W){1'b0}}, duty};
      REG_OFFSET: prdata = {{(DATA_W-OFS_W){1'b0}}, offset};
      default:    prdata = '0;
    endcase
  end

  // Serial divide and multiply for the pulse timing
  plpb_math u_math (
    .clk    (clk),
    .rst    (rst),
    .start  (math_go),
    .period (period_latched_next),
    .blen   (blen),
    .duty   (duty),
    .res    (math)
  );

  // Measure the reference period until locked
  always_comb begin
    armed_next          = armed;
    rise_cnt_next       = rise_cnt;
    edge_timer_next     = edge_timer;
    period_latched_next = period_latched;
    if (!locked) begin
      if (rise) begin
        if (armed) begin
          rise_cnt_next = rise_cnt + 2'd1;
        end
        if (lock_now) begin
          period_latched_next = sat_inc(edge_timer);
        end
        edge_timer_next = '0;
      end else if (fall && !armed) begin
        armed_next      = 1'b1;
        edge_timer_next = '0;
      end else begin
        edge_timer_next = sat_inc(edge_timer);
      end
    end
  end

  // Arm, wait and pulse
  always_comb begin
    rise_pending_next = rise_pending;
    since_rise_next   = sat_inc(since_rise);
    if (locked && rise) begin
      rise_pending_next = 1'b1;
      since_rise_next   = '0;
    end
    phase_next       = phase;
    phase_timer_next = phase_timer;
    pulses_done_next = pulses_done;
    trig_next        = 1'b0;
    if (phase_next == PH_IDLE && rise_pending_next) begin
      rise_pending_next = 1'b0;
      phase_next        = PH_WAIT;
    end
    if (phase_next == PH_WAIT && since_rise_next > offset) begin
      phase_next       = PH_PULSE;
      phase_timer_next = '0;
      pulses_done_next = '0;
    end
    if (phase_next == PH_PULSE) begin
      trig_next = (phase_timer_next <= math.high_time);
      if (phase_timer_next > math.thr) begin
        trig_next        = 1'b0;
        phase_timer_next = '0;
        pulses_done_next = pulses_done_next + CNT_W'(1);
        if (pulses_done_next >= blen) begin
          phase_next = PH_IDLE;
        end
      end else begin
        phase_timer_next = sat_inc(phase_timer_next);
      end
    end else if (phase_next != PH_WAIT) begin
      phase_next = PH_IDLE;
    end
  end

  assign res_new.trig   = trig_next;
  assign res_new.pvalid = (rise_cnt_next == LOCK_CNT);
  assign res_new.period = period_latched_next;
  assign res_new.busy   = (phase_next != PH_IDLE);

  // Advance the tick state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level     <= 1'b0;
      armed          <= 1'b0;
      rise_cnt       <= '0;
      edge_timer     <= '0;
      period_latched <= '0;
      phase          <= PH_IDLE;
      phase_timer    <= '0;
      pulses_done    <= '0;
      rise_pending   <= 1'b0;
      since_rise     <= '0;
    end else if (accept) begin
      last_level     <= ref_level;
      armed          <= armed_next;
      rise_cnt       <= rise_cnt_next;
      edge_timer     <= edge_timer_next;
      period_latched <= period_latched_next;
      phase          <= phase_next;
      phase_timer    <= phase_timer_next;
      pulses_done    <= pulses_done_next;
      rise_pending   <= rise_pending_next;
      since_rise     <= since_rise_next;
    end
  end

  // Output register with one spare slot; hold input while the slot is full or the math unit is busy
  assign out_free = !out_valid || !out_stall;
  assign in_stall = math.busy || res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      res_valid <= 1'b0;
    end else if (accept) begin
      if (out_free) begin
        out_valid <= 1'b1;
        out_res   <= res_new;
      end else begin
        res_valid <= 1'b1;
        res_slot  <= res_new;
      end
    end else if (res_valid && out_free) begin
      out_valid <= 1'b1;
      out_res   <= res_slot;
      res_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  assign trigger_level   = out_res.trig;
  assign period_valid    = out_res.pvalid;
  assign measured_period = out_res.period;
  assign burst_busy      = out_res.busy;

  // Bursts and pending rises exist only after lock; math never runs in a burst
  `PLPB_ASSERT(a_burst_after_lock, (phase != PH_IDLE) |-> locked, "burst before period lock")
  `PLPB_ASSERT(a_pending_after_lock, rise_pending |-> locked, "armed rise before period lock")
  `PLPB_ASSERT(a_math_idle_in_burst, (phase != PH_IDLE) |-> !math.busy, "math busy in burst")
  `PLPB_ASSERT_NEXT(a_math_on_lock, math_go, math.busy && locked, "math start without lock")

endmodule

[test/tb_period_locked_pulse_burst.sv]
module tb_period_locked_pulse_burst;
  timeunit 1ns;
  timeprecision 1ps;
  import plpb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LOCK_SETTLE = 120;
  localparam int PHASES = 6;
  localparam int TOTAL_TICKS = 1800;
  localparam int MIN_PHASE_TICKS = 50;
  localparam int MAX_REPORTS = 40;

  typedef enum logic [1:0] {BURST_IDLE, BURST_WAIT, BURST_FIRE} burst_state_t;

  typedef struct packed {
    logic             trigger;
    logic             locked;
    logic [TMR_W-1:0] period;
    logic             busy;
  } tick_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              ref_level = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              trigger_level;
  logic              period_valid;
  logic [TMR_W-1:0]  measured_period;
  logic              burst_busy;

  period_locked_pulse_burst dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .ref_level      (ref_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .trigger_level  (trigger_level),
    .period_valid   (period_valid),
    .measured_period(measured_period),
    .burst_busy     (burst_busy)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Reference level requests waiting to go out, and results still owed
  logic         request_q[$];
  tick_result_t expected_q[$];
  int           ticks_queued = 0;
  int           ticks_accepted = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  logic         gen_level = 1'b0;

  // Register copies
  logic [CNT_W-1:0]  cfg_count = PPP_RST;
  logic [DUTY_W-1:0] cfg_duty = DUTY_RST;
  logic [OFS_W-1:0]  cfg_offset = OFFSET_RST;

  // Predicted block state
  logic             prev_level = 1'b0;
  logic             fall_armed = 1'b0;
  logic [1:0]       rises_seen = '0;
  logic [TMR_W-1:0] edge_cnt = '0;
  logic [TMR_W-1:0] ref_period = '0;
  logic [TMR_W-1:0] slot_len = '0;
  logic [TMR_W-1:0] high_len = '0;
  burst_state_t     burst_st = BURST_IDLE;
  logic [TMR_W-1:0] slot_cnt = '0;
  logic [CNT_W-1:0] slots_done = '0;
  logic             rise_queued = 1'b0;
  logic [TMR_W-1:0] rise_age = '0;

  function automatic logic [TMR_W-1:0] bump(input logic [TMR_W-1:0] v);
    return (v == TMR_MAX) ? v : v + TMR_W'(1);
  endfunction

  // A pulse count of zero behaves as one
  function automatic logic [CNT_W-1:0] burst_len();
    return (cfg_count == '0) ? CNT_W'(1) : cfg_count;
  endfunction

  function automatic tick_result_t predict_tick(input logic lvl);
    logic         rise;
    logic         fall;
    logic         was_locked;
    logic         trig;
    logic [63:0]  prod;
    tick_result_t res;
    rise = lvl & ~prev_level;
    fall = ~lvl & prev_level;
    was_locked = (rises_seen >= 2'd2);
    trig = 1'b0;
    prev_level = lvl;
    // measure the reference period once, from the second rise after a fall
    if (!was_locked) begin
      edge_cnt = bump(edge_cnt);
      if (rise) begin
        if (fall_armed) begin
          rises_seen = rises_seen + 2'd1;
          if (rises_seen >= 2'd2) begin
            ref_period = edge_cnt;
            slot_len = ref_period / TMR_W'(burst_len());
            prod = (64'(slot_len) * 64'(cfg_duty)) >> DUTY_SHIFT;
            high_len = (prod > 64'(TMR_MAX)) ? TMR_MAX : prod[TMR_W-1:0];
          end
        end
        edge_cnt = '0;
      end else if (fall && !fall_armed) begin
        fall_armed = 1'b1;
        edge_cnt = '0;
      end
    end
    // arm a burst on each rise once locked
    if (was_locked && rise) begin
      rise_queued = 1'b1;
      rise_age = '0;
    end else begin
      rise_age = bump(rise_age);
    end
    if (burst_st == BURST_IDLE && rise_queued) begin
      rise_queued = 1'b0;
      burst_st = BURST_WAIT;
    end
    if (burst_st == BURST_WAIT && rise_age > cfg_offset) begin
      burst_st = BURST_FIRE;
      slot_cnt = '0;
      slots_done = '0;
    end
    // drive the pulse, close it just short of a full slot
    if (burst_st == BURST_FIRE) begin
      trig = (slot_cnt <= high_len);
      if (64'(slot_cnt) * THR_DEN_I > 64'(slot_len) * THR_NUM_I) begin
        trig = 1'b0;
        slot_cnt = '0;
        slots_done = slots_done + CNT_W'(1);
        if (slots_done >= burst_len()) burst_st = BURST_IDLE;
      end else begin
        slot_cnt = bump(slot_cnt);
      end
    end
    res.trigger = trig;
    res.locked = (rises_seen >= 2'd2);
    res.period = ref_period;
    res.busy = (burst_st != BURST_IDLE);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PPP:    cfg_count = value[CNT_W-1:0];
      REG_DUTY:   cfg_duty = value[DUTY_W-1:0];
      REG_OFFSET: cfg_offset = value[OFS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned cnt, input int unsigned duty,
                            input int unsigned ofs);
    write_reg(REG_PPP, cnt);
    write_reg(REG_DUTY, duty);
    write_reg(REG_OFFSET, ofs);
  endtask

  task automatic push_run(input logic level, input int n);
    for (int i = 0; i < n; i++) request_q.push_back(level);
    ticks_queued += n;
    gen_level = level;
  endtask

  // Alternate high and low runs, with the odd one-tick glitch
  task automatic queue_reference(input int count, input int run_lo, input int run_hi,
                                 input int glitch_pct);
    int run;
    while (count > 0) begin
      run = ($urandom_range(0, 99) < glitch_pct) ? 1 : $urandom_range(run_lo, run_hi);
      if (run > count) run = count;
      push_run(~gen_level, run);
      count -= run;
    end
  endtask

  // Wait out every owed result, then the lock arithmetic
  task automatic drain();
    while (ticks_accepted != ticks_queued || expected_q.size() != 0) @(posedge clk);
    repeat (LOCK_SETTLE) @(posedge clk);
  endtask

  // Request driver: bursts of ticks separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // predict the tick taken at this edge
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_tick(ref_level));
        ticks_accepted++;
      end
      // advance unless the current request is held
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          ref_level <= request_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with a rotating stall pattern
  logic [15:0] stall_bits = '0;
  int          stall_cycle = 0;

  always @(posedge clk) begin : result_check
    tick_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      // compare the request taken at this edge
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with none expected, got trigger %0d", $time,
                     trigger_level);
        end else begin
          want = expected_q.pop_front();
          if (trigger_level !== want.trigger)
            report_mismatch("trigger_level", 32'(want.trigger), 32'(trigger_level));
          if (period_valid !== want.locked)
            report_mismatch("period_valid", 32'(want.locked), 32'(period_valid));
          if (measured_period !== want.period)
            report_mismatch("measured_period", 32'(want.period), 32'(measured_period));
          if (burst_busy !== want.busy)
            report_mismatch("burst_busy", 32'(want.busy), 32'(burst_busy));
        end
      end
      // from time to time pick a new stall pattern: none, random, sparse or dense
      if (stall_cycle % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_bits = '0;
          1: stall_bits = 16'($urandom);
          2: stall_bits = 16'($urandom & $urandom);
          default: stall_bits = 16'($urandom | $urandom);
        endcase
      end
      stall_cycle++;
      out_stall <= stall_bits[0];
      stall_bits = {stall_bits[0], stall_bits[15:1]};
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned period_ticks;
    int unsigned high_ticks;
    int unsigned lock_count;
    int unsigned lock_duty;
    int          phase_ticks;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // pick the settings in force when the period locks
    if ($urandom_range(0, 3) == 0) begin
      period_ticks = $urandom_range(1000, 1400);
      lock_count = $urandom_range(0, 1);
    end else begin
      period_ticks = $urandom_range(6, 60);
      lock_count = $urandom_range(0, 6);
    end
    case ($urandom_range(0, 4))
      0: lock_duty = 0;
      1: lock_duty = 2047;
      2: lock_duty = 1024;
      3: lock_duty = 512;
      default: lock_duty = $urandom_range(1, 2046);
    endcase
    set_config(lock_count, lock_duty, $urandom_range(0, 20));

    // rise before any fall, the arming fall, then two rises one period apart
    push_run(1'b1, 2);
    push_run(1'b0, 3);
    high_ticks = $urandom_range(1, period_ticks - 1);
    push_run(1'b1, high_ticks);
    push_run(1'b0, period_ticks - high_ticks);
    push_run(1'b1, 1);
    // first burst rises, one landing during the wait or the burst
    push_run(1'b0, 2);
    push_run(1'b1, 3);
    push_run(1'b0, 4);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    drain();

    // share the remaining tick budget among the phases
    if (TOTAL_TICKS - ticks_queued > PHASES * MIN_PHASE_TICKS)
      phase_ticks = (TOTAL_TICKS - ticks_queued) / PHASES;
    else
      phase_ticks = MIN_PHASE_TICKS;

    // random phases, each under new register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(1, 0, 0);
        1: set_config(255, 2047, $urandom_range(0, 40));
        2: set_config(0, 1024, 32'(TMR_MAX));
        default:
          set_config($urandom_range(0, 9), $urandom_range(0, 2047),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, 150));
      endcase
      case ($urandom_range(0, 5))
        0: queue_reference(phase_ticks, 1, 4, 10);
        4: queue_reference(phase_ticks, 10, 400, 2);
        5: queue_reference(phase_ticks, 1, 12, 20);
        default: queue_reference(phase_ticks, 2, 40, 3);
      endcase
      drain();
    end

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
